### rtl/core/upd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package upd_pkg;

    localparam logic [7:0] PCT_CHAR   = 8'h25;
    localparam logic [7:0] PLUS_CHAR  = 8'h2B;
    localparam logic [7:0] SPACE_CHAR = 8'h20;

    // The queue depth must be a power of two so that the pointers wrap on their own.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_PCT   = 2'd1,
        PH_DIGIT = 2'd2
    } phase_t;

    // One decoded run: up to three bytes, how many are used, and the end-of-text flag.
    typedef struct packed {
        logic [2:0][7:0] data;
        logic [1:0]      cnt;
        logic            last;
    } cmd_t;

    function automatic logic is_hex(input logic [7:0] c);
        return (c >= 8'd48 && c <= 8'd57) || (c >= 8'd65 && c <= 8'd70) ||
               (c >= 8'd97 && c <= 8'd102);
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        return c[6] ? (c[3:0] + 4'd9) : c[3:0];
    endfunction

    function automatic logic is_safe(input logic [7:0] v);
        return (v >= 8'd48 && v <= 8'd57) || (v >= 8'd97 && v <= 8'd122) ||
               (v >= 8'd65 && v <= 8'd90) || (v == 8'h21) || (v == 8'h24) ||
               (v >= 8'h26 && v <= 8'h2f) || (v == 8'h3A) || (v == 8'h3B) ||
               (v == 8'h3D) || (v == 8'h3f) || (v == 8'h40) || (v == 8'h5f);
    endfunction

    function automatic cmd_t cmd_push(input cmd_t c, input logic [7:0] x);
        cmd_t r;
        r = c;
        r.data[c.cnt] = x;
        r.cnt = c.cnt + 2'd1;
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/core/upd_front.sv
`timescale 1ns / 1ps
`default_nettype none

module upd_front
    import upd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // in_byte
    input  wire logic       s_tlast,   // in_last
    input  wire logic       q_full,
    output logic            push,
    output cmd_t            cmd
);

    phase_t     phase_reg, phase_next, phase_mid;
    logic [7:0] digit_reg, digit_next;
    logic       accept;
    logic [7:0] b;
    logic       b_hex;
    logic [7:0] fresh_byte;
    logic [7:0] dec_val;

    assign b          = s_tdata;
    assign b_hex      = is_hex(b);
    assign fresh_byte = (b == PLUS_CHAR) ? SPACE_CHAR : b;
    assign dec_val    = {hex_val(digit_reg), hex_val(b)};
    assign s_tready   = !q_full;
    assign accept     = s_tvalid && s_tready;
    assign push       = accept && (cmd.cnt != 2'd0);

    always_comb
    begin
        unique case (phase_reg)
            PH_PCT:   phase_mid = b_hex ? PH_DIGIT : ((b == PCT_CHAR) ? PH_PCT : PH_IDLE);
            PH_DIGIT: phase_mid = b_hex ? PH_IDLE : ((b == PCT_CHAR) ? PH_PCT : PH_IDLE);
            default:  phase_mid = (b == PCT_CHAR) ? PH_PCT : PH_IDLE;
        endcase
        phase_next = s_tlast ? PH_IDLE : phase_mid;
        digit_next = digit_reg;
        if (phase_reg == PH_PCT && b_hex)
        begin
            digit_next = b;
        end
        if (s_tlast)
        begin
            digit_next = 8'd0;
        end
    end

    always_comb
    begin
        cmd = '0;
        cmd.last = s_tlast;
        unique case (phase_reg)
            PH_PCT:
            begin
                if (!b_hex)
                begin
                    cmd = cmd_push(cmd, PCT_CHAR);
                    if (b != PCT_CHAR)
                    begin
                        cmd = cmd_push(cmd, fresh_byte);
                    end
                end
            end
            PH_DIGIT:
            begin
                if (b_hex)
                begin
                    if (is_safe(dec_val))
                    begin
                        cmd = cmd_push(cmd, PCT_CHAR);
                        cmd = cmd_push(cmd, digit_reg);
                        cmd = cmd_push(cmd, b);
                    end
                    else
                    begin
                        cmd = cmd_push(cmd, dec_val);
                    end
                end
                else
                begin
                    cmd = cmd_push(cmd, PCT_CHAR);
                    cmd = cmd_push(cmd, digit_reg);
                    if (b != PCT_CHAR)
                    begin
                        cmd = cmd_push(cmd, fresh_byte);
                    end
                end
            end
            default:
            begin
                if (b != PCT_CHAR)
                begin
                    cmd = cmd_push(cmd, fresh_byte);
                end
            end
        endcase
        if (s_tlast)
        begin
            if (phase_mid == PH_PCT)
            begin
                cmd = cmd_push(cmd, PCT_CHAR);
            end
            else if (phase_mid == PH_DIGIT)
            begin
                // The held digit is the byte of this transaction.
                cmd = cmd_push(cmd, PCT_CHAR);
                cmd = cmd_push(cmd, b);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            digit_reg <= 8'd0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            digit_reg <= digit_next;
        end
    end

    a_last_pushes: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s_tlast) |-> push)
        else $error("final byte produced no output");

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s_tlast) |=> (phase_reg == PH_IDLE))
        else $error("escape still pending after final byte");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> !push)
        else $error("push while queue full");

endmodule

`default_nettype wire

### rtl/core/upd_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module upd_fifo
    import upd_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire cmd_t push_cmd,
    input  wire logic pop,
    output logic      full,
    output logic      empty,
    output cmd_t      head
);

    cmd_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;

    assign full  = (cnt_reg == QCNT_W'(QDEPTH));
    assign empty = (cnt_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            cnt_reg <= cnt_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        empty |-> !pop)
        else $error("queue underflow");

    a_ptr_count: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_ptr_reg - rd_ptr_reg) == cnt_reg[QPTR_W-1:0])
        else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

### rtl/core/upd_back.sv
`timescale 1ns / 1ps
`default_nettype none

module upd_back
    import upd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       q_empty,
    input  wire cmd_t       head,
    output logic            pop,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // out_byte
    output logic            m_tuser,   // run_last
    output logic            m_tlast    // text_end
);

    logic [1:0] idx_reg, idx_next;
    logic       fin;
    logic       xfer;

    assign m_tvalid = !q_empty;
    assign m_tdata  = head.data[idx_reg];
    assign fin      = (idx_reg == (head.cnt - 2'd1));
    assign m_tuser  = fin;
    assign m_tlast  = fin && head.last;
    assign xfer     = m_tvalid && m_tready;
    assign pop      = xfer && fin;

    always_comb
    begin
        idx_next = idx_reg;
        if (xfer)
        begin
            idx_next = fin ? 2'd0 : (idx_reg + 2'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= 2'd0;
        end
        else
        begin
            idx_reg <= idx_next;
        end
    end

    a_idx_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (idx_reg < head.cnt))
        else $error("byte index beyond run length");

    a_end_is_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        m_tlast |-> m_tuser)
        else $error("text end not on run end");

    a_pop_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (idx_reg == 2'd0))
        else $error("index not cleared after run");

endmodule

`default_nettype wire

### rtl/core/url_percent_decoder_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Signals                          Payload
// s_*      in   s_tvalid s_tready s_tdata s_tlast  in_byte, in_last
// m_*      out  m_tvalid m_tready m_tdata m_tuser  out_byte, run_last, text_end (tlast)
//
// An input transaction is classified in the cycle it is accepted and its decoded run
// goes into a four-entry queue; the output side sends one byte per cycle from it while
// m_tready is high. Ordinary bytes and escapes that decode to one byte sustain one
// transaction per cycle; a run of two or three bytes is sent one byte at a time, and
// input stalls only when the queue fills. A '%' with no result yet produces no output
// transaction. Reset clears the escape state and empties the queue.

module url_percent_decoder_unit
    import upd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // in_byte
    input  wire logic       s_tlast,   // in_last
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // out_byte
    output logic            m_tuser,   // run_last
    output logic            m_tlast    // text_end
);

    logic push, pop, q_full, q_empty;
    cmd_t cmd, head;

    upd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .push     (push),
        .cmd      (cmd)
    );

    upd_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (cmd),
        .pop      (pop),
        .full     (q_full),
        .empty    (q_empty),
        .head     (head)
    );

    upd_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .head     (head),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

### dv/tb.sv
`timescale 1ns / 1ps

module tb;
    import upd_pkg::*;

    localparam int LIMIT_CYCLES = 200000;
    localparam int HOLD_CYCLES = 80;
    localparam int HOLD_AT = 180;
    localparam int STEADY_FROM = 60;
    localparam int STEADY_TO = 130;
    localparam int DRAIN_AT = 230;
    // A random text adds at most thirty bytes, so this window is never skipped.
    localparam int DRAIN_SPAN = 30;
    localparam int RANDOM_ITEMS = 300;
    localparam int SETTLE_CYCLES = 20;

    typedef struct {
        logic [7:0] data;
        logic       last;
        logic       drain;
    } text_item_t;

    typedef struct {
        logic [7:0] out_byte;
        logic       run_last;
        logic       text_end;
    } decoded_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;
    logic       s_tlast = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tuser;
    logic       m_tlast;

    text_item_t pending_q[$];
    decoded_t   decoded_q[$];

    phase_t     dec_phase = PH_IDLE;
    logic [7:0] held_digit = 8'h00;
    logic [7:0] run_buf[3];
    int         run_len;

    int         accepted_count = 0;
    int         out_count = 0;
    int         error_count = 0;
    int         cycle_count = 0;
    int         hold_left = 0;
    logic       hold_done = 1'b0;
    logic       steady;

    assign steady = (accepted_count >= STEADY_FROM) && (accepted_count < STEADY_TO);

    url_percent_decoder_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #5 clk = ~clk;

    function automatic logic is_hex_char(input logic [7:0] c);
        return (c >= 8'd48 && c <= 8'd57) || (c >= 8'd65 && c <= 8'd70) ||
               (c >= 8'd97 && c <= 8'd102);
    endfunction

    function automatic logic [3:0] nibble(input logic [7:0] c);
        logic [7:0] v;
        if (c <= 8'd57)
            v = c - 8'd48;
        else if (c <= 8'd70)
            v = c - 8'd55;
        else
            v = c - 8'd87;
        return v[3:0];
    endfunction

    function automatic logic url_safe(input logic [7:0] v);
        return (v >= 8'd48 && v <= 8'd57) || (v >= 8'd97 && v <= 8'd122) ||
               (v >= 8'd65 && v <= 8'd90) || v == 8'h21 || v == 8'h24 ||
               (v >= 8'h26 && v <= 8'h2f) || v == 8'h3a || v == 8'h3b ||
               v == 8'h3d || v == 8'h3f || v == 8'h40 || v == 8'h5f;
    endfunction

    function automatic logic [7:0] random_hex_char();
        logic [3:0] v;
        v = 4'($urandom_range(15));
        if (v < 4'd10)
            return 8'd48 + v;
        else if ($urandom_range(1) == 0)
            return 8'd55 + v;
        else
            return 8'd87 + v;
    endfunction

    // Results beyond the third of one step are dropped.
    task automatic emit(input logic [7:0] b);
        if (run_len < 3)
        begin
            run_buf[run_len] = b;
            run_len++;
        end
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic last);
        logic       fresh;
        logic [7:0] v;
        decoded_t   r;
        run_len = 0;
        fresh = 1'b0;
        case (dec_phase)
            PH_PCT:
                if (is_hex_char(b))
                begin
                    held_digit = b;
                    dec_phase = PH_DIGIT;
                end
                else
                begin
                    emit(PCT_CHAR);
                    dec_phase = PH_IDLE;
                    fresh = 1'b1;
                end
            PH_DIGIT:
                if (is_hex_char(b))
                begin
                    v = {nibble(held_digit), nibble(b)};
                    dec_phase = PH_IDLE;
                    if (url_safe(v))
                    begin
                        emit(PCT_CHAR);
                        emit(held_digit);
                        emit(b);
                    end
                    else
                        emit(v);
                end
                else
                begin
                    emit(PCT_CHAR);
                    emit(held_digit);
                    dec_phase = PH_IDLE;
                    fresh = 1'b1;
                end
            default:
            begin
                dec_phase = PH_IDLE;
                fresh = 1'b1;
            end
        endcase
        if (fresh)
        begin
            if (b == PCT_CHAR)
                dec_phase = PH_PCT;
            else if (b == PLUS_CHAR)
                emit(SPACE_CHAR);
            else
                emit(b);
        end
        if (last)
        begin
            if (dec_phase == PH_PCT)
                emit(PCT_CHAR);
            else if (dec_phase == PH_DIGIT)
            begin
                emit(PCT_CHAR);
                emit(held_digit);
            end
            dec_phase = PH_IDLE;
            held_digit = 8'h00;
        end
        for (int i = 0; i < run_len; i++)
        begin
            r.out_byte = run_buf[i];
            r.run_last = (i == run_len - 1);
            r.text_end = (i == run_len - 1) && last;
            decoded_q.insert(decoded_q.size(), r);
        end
    endtask

    task automatic report_mismatch(input string msg);
        $display("mismatch: %s", msg);
        error_count++;
    endtask

    task automatic add_item(input logic [7:0] b, input logic last, input logic drain);
        text_item_t it;
        it.data = b;
        it.last = last;
        it.drain = drain;
        pending_q.insert(pending_q.size(), it);
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            add_item(s[i], i == s.len() - 1, 1'b0);
    endtask

    task automatic add_random_text(input logic drain);
        logic [7:0] bytes[$];
        logic [7:0] b;
        int         tokens;
        int         kind;
        tokens = $urandom_range(10, 1);
        for (int t = 0; t < tokens; t++)
        begin
            kind = $urandom_range(99);
            if (kind < 35)
            begin
                bytes.insert(bytes.size(), PCT_CHAR);
                bytes.insert(bytes.size(), random_hex_char());
                bytes.insert(bytes.size(), random_hex_char());
            end
            else if (kind < 47)
            begin
                bytes.insert(bytes.size(), PCT_CHAR);
                if ($urandom_range(1) == 1)
                    bytes.insert(bytes.size(), random_hex_char());
                if ($urandom_range(3) != 0)
                begin
                    do
                        b = 8'($urandom_range(255));
                    while (is_hex_char(b));
                    bytes.insert(bytes.size(), b);
                end
            end
            else if (kind < 57)
                bytes.insert(bytes.size(), PLUS_CHAR);
            else if (kind < 77)
                bytes.insert(bytes.size(), 8'($urandom_range(8'h7e, 8'h20)));
            else
                bytes.insert(bytes.size(), 8'($urandom_range(255)));
        end
        foreach (bytes[i])
            add_item(bytes[i], i == bytes.size() - 1, drain && i == 0);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : drive_proc
        text_item_t it;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= 8'h00;
            s_tlast <= 1'b0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (pending_q.size() != 0 &&
                (!pending_q[0].drain || (!s_tvalid && decoded_q.size() == 0)) &&
                (steady || $urandom_range(99) >= 36))
            begin
                it = pending_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= it.data;
                s_tlast <= it.last;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (!hold_done && accepted_count >= HOLD_AT)
        begin
            m_tready <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else
            m_tready <= steady || ($urandom_range(99) >= 36);
    end

    always @(posedge clk)
    begin : monitor_proc
        decoded_t e;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                decode_byte(s_tdata, s_tlast);
                accepted_count <= accepted_count + 1;
            end
            if (m_tvalid && m_tready)
            begin
                if (decoded_q.size() == 0)
                    report_mismatch($sformatf("unexpected output transaction %0d, byte %02h",
                                              out_count, m_tdata));
                else
                begin
                    e = decoded_q.pop_front();
                    if (m_tdata !== e.out_byte)
                        report_mismatch($sformatf("output %0d out_byte %02h, expected %02h",
                                                  out_count, m_tdata, e.out_byte));
                    if (m_tuser !== e.run_last)
                        report_mismatch($sformatf("output %0d run_last %b, expected %b",
                                                  out_count, m_tuser, e.run_last));
                    if (m_tlast !== e.text_end)
                        report_mismatch($sformatf("output %0d text_end %b, expected %b",
                                                  out_count, m_tlast, e.text_end));
                end
                out_count++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, decoded_q.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        add_text("+%41%20%fF%z%4g%%3a%4");
        add_text("%");
        add_item(8'h00, 1'b0, 1'b0);
        add_item(8'hff, 1'b0, 1'b0);
        add_item(8'h80, 1'b0, 1'b0);
        add_item(8'h41, 1'b1, 1'b0);
        add_text("%4%");
        while (pending_q.size() < RANDOM_ITEMS)
            add_random_text(pending_q.size() >= DRAIN_AT &&
                            pending_q.size() < DRAIN_AT + DRAIN_SPAN);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_q.size() != 0 || s_tvalid || decoded_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (decoded_q.size() != 0)
            report_mismatch($sformatf("%0d expected results never arrived", decoded_q.size()));
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
